// ===== hdl/hcr_pkg.sv =====
// ----------------------------------------------------------------------------
// hcr_pkg
// Types, codes and name tables shared by the character reference decoder.
// ----------------------------------------------------------------------------
package hcr_pkg;

  localparam int unsigned CP_W = 31;
  localparam logic [CP_W-1:0] CP_MAX = {CP_W{1'b1}};
  localparam int unsigned NUM_NAMES = 4;

  // Result status codes
  localparam logic [1:0] ST_CONT = 2'd0;
  localparam logic [1:0] ST_DONE = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  // Input kind
  localparam logic FUNC_FEED    = 1'b0;
  localparam logic FUNC_RESTART = 1'b1;

  // Parser mode, one-hot
  typedef enum logic [6:0] {
    M_START = 7'b0000001,
    M_AMP   = 7'b0000010,
    M_NUM   = 7'b0000100,
    M_DEC   = 7'b0001000,
    M_HEX   = 7'b0010000,
    M_NAMED = 7'b0100000,
    M_DONE  = 7'b1000000
  } mode_t;

  typedef struct packed {
    logic       func;
    logic [7:0] ch;
  } item_t;

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            code_valid;
    logic [1:0]      status;
  } result_t;

  // Name index: 0 amp, 1 gt, 2 lt, 3 quot
  function automatic logic [2:0] name_len(input logic [1:0] idx);
    logic [2:0] len;
    case (idx)
      2'd0:    len = 3'd3;
      2'd1:    len = 3'd2;
      2'd2:    len = 3'd2;
      default: len = 3'd4;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] name_code(input logic [1:0] idx);
    logic [7:0] code;
    case (idx)
      2'd0:    code = 8'h26;  // &
      2'd1:    code = 8'h3E;  // >
      2'd2:    code = 8'h3C;  // <
      default: code = 8'h22;  // "
    endcase
    return code;
  endfunction

  function automatic logic [7:0] name_char(input logic [1:0] idx, input logic [1:0] pos);
    logic [7:0] c;
    case ({idx, pos})
      4'b00_00: c = "a";
      4'b00_01: c = "m";
      4'b00_10: c = "p";
      4'b01_00: c = "g";
      4'b01_01: c = "t";
      4'b10_00: c = "l";
      4'b10_01: c = "t";
      4'b11_00: c = "q";
      4'b11_01: c = "u";
      4'b11_10: c = "o";
      4'b11_11: c = "t";
      default:  c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== hdl/hcr_in_stage.sv =====
// ----------------------------------------------------------------------------
// hcr_in_stage
// Input register: holds one item until the decoder core takes it.
// ----------------------------------------------------------------------------
module hcr_in_stage
  import hcr_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  s_axis_tvalid,
  output logic  s_axis_tready,
  input  item_t s_item,
  input  logic  advance,
  output logic  in_valid,
  output item_t in_item
);

  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item <= s_item;
    end
  end

endmodule

// ===== hdl/hcr_core.sv =====
// ----------------------------------------------------------------------------
// hcr_core
// Parser state and the per-byte update: mode step, numeric multiply-add with
// saturation and a parallel match against the four names.
// ----------------------------------------------------------------------------
module hcr_core
  import hcr_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    fire,
  input  item_t   item,
  output result_t result
);

  mode_t           mode, mode_next;
  logic [CP_W-1:0] acc, acc_next;
  logic [3:0]      alive, alive_next;
  logic [2:0]      pos, pos_next;
  logic            failed, failed_next;

  logic [7:0]  c;
  logic        is_dec, is_hex, is_semi;
  logic [3:0]  dec_digit, hex_digit;
  logic [34:0] dec_sum, hex_sum;
  logic [CP_W-1:0] dec_sat, hex_sat;

  // name match
  logic [3:0]  cont_hits;
  logic        semi_hit;
  logic [7:0]  semi_code;
  logic [1:0]  name_st;
  logic        name_fail_set;
  logic        name_done;

  logic [1:0]  status;

  assign c       = item.ch;
  assign is_semi = (c == ";");
  assign is_dec  = (c >= "0") && (c <= "9");
  assign dec_digit = 4'(c - "0");

  always_comb begin
    is_hex    = 1'b1;
    hex_digit = 4'd0;
    if (is_dec) begin
      hex_digit = dec_digit;
    end else if (c >= "a" && c <= "f") begin
      hex_digit = 4'(c - "a" + 8'd10);
    end else if (c >= "A" && c <= "F") begin
      hex_digit = 4'(c - "A" + 8'd10);
    end else begin
      is_hex = 1'b0;
    end
  end

  assign dec_sum = 35'(acc) * 35'd10 + 35'(dec_digit);
  assign hex_sum = {acc, 4'b0000} + 35'(hex_digit);
  assign dec_sat = (dec_sum > 35'(CP_MAX)) ? CP_MAX : dec_sum[CP_W-1:0];
  assign hex_sat = (hex_sum > 35'(CP_MAX)) ? CP_MAX : hex_sum[CP_W-1:0];

  // Name state seen by the matcher; after '&' the name state is fresh.
  logic [3:0] m_alive;
  logic [2:0] m_pos;
  logic       m_failed;

  always_comb begin
    if (mode == M_AMP) begin
      m_alive  = 4'hF;
      m_pos    = 3'd0;
      m_failed = 1'b0;
    end else begin
      m_alive  = alive;
      m_pos    = pos;
      m_failed = failed;
    end
  end

  always_comb begin
    semi_hit  = 1'b0;
    semi_code = 8'h00;
    cont_hits = 4'h0;
    // walk down so the lowest matching name wins
    for (int i = NUM_NAMES - 1; i >= 0; i--) begin
      if (m_alive[i] && name_len(2'(i)) == m_pos) begin
        semi_hit  = 1'b1;
        semi_code = name_code(2'(i));
      end
      cont_hits[i] = m_alive[i] && (m_pos < name_len(2'(i)))
                     && (name_char(2'(i), m_pos[1:0]) == c);
    end
  end

  always_comb begin
    name_st       = ST_BAD;
    name_fail_set = 1'b0;
    name_done     = 1'b0;
    if (m_failed) begin
      name_st = ST_BAD;
    end else if (is_semi) begin
      if (semi_hit) begin
        name_st   = ST_DONE;
        name_done = 1'b1;
      end else begin
        name_fail_set = 1'b1;
      end
    end else if (cont_hits != 4'h0) begin
      name_st = ST_CONT;
    end else begin
      name_fail_set = 1'b1;
    end
  end

  always_comb begin
    mode_next   = mode;
    acc_next    = acc;
    alive_next  = alive;
    pos_next    = pos;
    failed_next = failed;
    status      = ST_BAD;
    unique case (mode)
      M_START: begin
        if (c == "&") begin
          mode_next = M_AMP;
          status    = ST_CONT;
        end
      end
      M_AMP, M_NAMED: begin
        if (mode == M_NAMED || (c != "#" && !is_semi)) begin
          mode_next = M_NAMED;
          if (mode == M_AMP) begin
            acc_next = '0;
          end
          status = name_st;
          if (name_fail_set) begin
            failed_next = 1'b1;
          end
          if (name_done) begin
            acc_next  = CP_W'(semi_code);
            mode_next = M_DONE;
          end else if (name_st == ST_CONT) begin
            alive_next = cont_hits;
            pos_next   = m_pos + 3'd1;
          end
        end else if (c == "#") begin
          mode_next = M_NUM;
          status    = ST_CONT;
        end
      end
      M_NUM: begin
        if (c == "x" || c == "X") begin
          mode_next = M_HEX;
          status    = ST_CONT;
        end else if (is_dec) begin
          mode_next = M_DEC;
          acc_next  = CP_W'(dec_digit);
          status    = ST_CONT;
        end
      end
      M_DEC: begin
        if (is_dec) begin
          acc_next = dec_sat;
          status   = ST_CONT;
        end else if (is_semi) begin
          mode_next = M_DONE;
          status    = ST_DONE;
        end
      end
      M_HEX: begin
        if (is_hex) begin
          acc_next = hex_sat;
          status   = ST_CONT;
        end else if (is_semi) begin
          mode_next = M_DONE;
          status    = ST_DONE;
        end
      end
      M_DONE: begin
        status = ST_BAD;
      end
      default: begin
        status = ST_BAD;
      end
    endcase
  end

  always_comb begin
    if (item.func == FUNC_RESTART) begin
      result.status     = ST_CONT;
      result.code_valid = 1'b0;
      result.code_point = '0;
    end else begin
      result.status     = status;
      result.code_valid = (mode_next == M_DONE);
      result.code_point = (mode_next == M_DONE) ? acc_next : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (fire && item.func == FUNC_RESTART)) begin
      mode   <= M_START;
      acc    <= '0;
      alive  <= 4'hF;
      pos    <= 3'd0;
      failed <= 1'b0;
    end else if (fire) begin
      mode   <= mode_next;
      acc    <= acc_next;
      alive  <= alive_next;
      pos    <= pos_next;
      failed <= failed_next;
    end
  end

endmodule

// ===== hdl/html_char_reference_decoder.sv =====
// ----------------------------------------------------------------------------
// html_char_reference_decoder
// Decodes one HTML character reference (decimal, hex or named) a byte at a
// time and reports a status and the code point for every byte.
//
//   channel  dir  tdata                                   tuser
//   s_axis   in   [7:0] ch                                [0] func
//   m_axis   out  [1:0] status, [2] code_valid,           -
//                 [33:3] code_point, [39:34] zero
//
// One item per cycle sustained while m_axis_tready is high; a result is
// offered once its item has passed the input register and then the result
// register. The parser state is updated in the cycle the core takes an item,
// so each byte sees the state left by the one before. A stalled result holds
// the result register and the input register, and s_axis_tready drops once
// both are full. rst clears the parser and both valid flags.
// ----------------------------------------------------------------------------
module html_char_reference_decoder
  import hcr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] ch
  input  logic        s_axis_tuser,   // [0] func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // [1:0] status, [2] code_valid, [33:3] code_point
);

  item_t   s_item;
  item_t   in_item;
  logic    in_valid;
  logic    advance;
  logic    fire;
  result_t result;
  result_t out_result;

  assign s_item.func = s_axis_tuser;
  assign s_item.ch   = s_axis_tdata;

  // result register frees when empty or being taken
  assign advance = !m_axis_tvalid || m_axis_tready;
  assign fire    = in_valid && advance;

  hcr_in_stage u_in_stage (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_item        (s_item),
    .advance       (advance),
    .in_valid      (in_valid),
    .in_item       (in_item)
  );

  hcr_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (in_item),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_result <= result;
    end
  end

  assign m_axis_tdata = {6'b000000, out_result};

endmodule
